// ===== rtl/core/rbf_pkg.sv =====
// Shared types, codes and defaults of the request batch former.
package rbf_pkg;

    // Defaults of the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_LANES_DEF   = 16;
    localparam int STAMP_BITS_DEF  = 32;

    // Command queue between the front and the back end
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_PASS = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_QUEUED  = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_ZERO    = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_TAKEN   = 3'd4;
    localparam logic [2:0] KIND_SENT    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LANES     = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] size;
        logic [15:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [15:0] max_batch_size;
        logic [19:0] queue_timeout;
        logic [19:0] batching_interval;
        logic [4:0]  lane_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] tag;
        logic [3:0]  lane;
        logic [15:0] batch_total;
        logic [15:0] batch_members;
        logic [31:0] batch_start;
        logic        was_full;
        logic        last;
    } result_t;

    // Result about a single request: batch fields zero
    function automatic result_t note(input logic [2:0] kind, input logic [15:0] tag);
        result_t r;
        r      = '0;
        r.kind = kind;
        r.tag  = tag;
        return r;
    endfunction

endpackage

// ===== rtl/core/rbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rbf_front.sv =====
// Front end: accepts input beats, drops unknown commands, queues the rest.
module rbf_front import rbf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_size, request_tag
    input  logic [S_TUSER_W-1:0] s_tuser,   // command
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop
);

    cmd_t               cmdq_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               push;
    logic               pop;
    cmd_t               in_cmd;

    assign s_tready  = (count_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmdq_reg[rd_ptr_reg];

    always_comb begin
        in_cmd.op   = s_tuser;
        in_cmd.size = s_tdata[15:0];
        in_cmd.tag  = s_tdata[31:16];
        // unknown commands leave no trace
        push        = s_tvalid && s_tready && (s_tuser != CMD_NONE);
        pop         = cmd_pop && cmd_valid;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CMDQ_CW'(push) - CMDQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            cmdq_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/rbf_engine.sv =====
// Back end: pending FIFO, batch forming sequencer and result register.
module rbf_engine import rbf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_LANES   = MAX_LANES_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    out_valid,
    output result_t out_res,
    input  logic    out_ready
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int ENT_W  = 32 + STAMP_BITS;
    localparam int CMP_W  = (STAMP_BITS > 20) ? STAMP_BITS : 20;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_FINAL, S_FLUSH} state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [STAMP_BITS-1:0] now_reg, now_next;
    logic [15:0]           open_total_reg, open_total_next;
    logic [15:0]           open_members_reg, open_members_next;
    logic                  open_started_reg, open_started_next;
    logic [STAMP_BITS-1:0] open_stamp_reg, open_stamp_next;
    logic [LANE_W-1:0]     next_lane_reg, next_lane_next;
    logic                  full_reg, full_next;
    logic                  hold_valid_reg, hold_valid_next;
    result_t               hold_reg, hold_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg, out_res_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;
    logic [15:0]           ent_size;
    logic [15:0]           ent_tag;
    logic [STAMP_BITS-1:0] ent_stamp;

    logic                  out_free;
    logic                  can_emit;
    logic                  emit_req;
    result_t               emit_res;
    logic                  out_push;
    result_t               push_res;

    logic [STAMP_BITS-1:0] age;
    logic [STAMP_BITS-1:0] batch_age;
    logic                  timed_out;
    logic                  interval_up;
    logic [16:0]           grown_total;
    logic                  overflows;
    logic [6:0]            lane_cnt;
    logic [6:0]            lane_sel;
    logic [6:0]            lane_inc;
    logic [63:0]           stamp_ext;

    rbf_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_pending (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    assign ram_wdata = {now_reg, cmd.tag, cmd.size};
    assign ent_size  = ram_rdata[15:0];
    assign ent_tag   = ram_rdata[31:16];
    assign ent_stamp = ram_rdata[ENT_W-1:32];

    assign out_free  = !out_valid_reg || out_ready;
    assign can_emit  = !hold_valid_reg || out_free;

    always_comb begin
        age         = now_reg - ent_stamp;
        batch_age   = now_reg - open_stamp_reg;
        timed_out   = CMP_W'(age) >= CMP_W'(cfg.queue_timeout);
        interval_up = CMP_W'(batch_age) >= CMP_W'(cfg.batching_interval);
        grown_total = {1'b0, open_total_reg} + {1'b0, ent_size};
        overflows   = (open_total_reg != '0) && (grown_total > {1'b0, cfg.max_batch_size});
        // effective lane count: zero counts as one, clip at the lane limit
        if (cfg.lane_count == '0) begin
            lane_cnt = 7'd1;
        end else if (7'(cfg.lane_count) > 7'(MAX_LANES)) begin
            lane_cnt = 7'(MAX_LANES);
        end else begin
            lane_cnt = 7'(cfg.lane_count);
        end
        lane_sel  = (7'(next_lane_reg) < lane_cnt) ? 7'(next_lane_reg) : 7'd0;
        lane_inc  = (lane_sel + 7'd1 >= lane_cnt) ? 7'd0 : lane_sel + 7'd1;
        stamp_ext = 64'(open_stamp_reg);
    end

    always_comb begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        occ_next          = occ_reg;
        now_next          = now_reg;
        open_total_next   = open_total_reg;
        open_members_next = open_members_reg;
        open_started_next = open_started_reg;
        open_stamp_next   = open_stamp_reg;
        next_lane_next    = next_lane_reg;
        full_next         = full_reg;
        hold_valid_next   = hold_valid_reg;
        hold_next         = hold_reg;
        out_valid_next    = out_valid_reg;
        out_res_next      = out_res_reg;
        cmd_pop           = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        emit_req          = 1'b0;
        emit_res          = '0;
        out_push          = 1'b0;
        push_res          = hold_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        CMD_ENQ: begin
                            emit_req   = 1'b1;
                            state_next = S_FLUSH;
                            if (cmd.size == '0) begin
                                emit_res = note(KIND_ZERO, cmd.tag);
                            end else if (occ_reg == OCC_W'(QUEUE_DEPTH)) begin
                                emit_res = note(KIND_FULL, cmd.tag);
                            end else begin
                                ram_we    = 1'b1;
                                tail_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : tail_reg + 1'b1;
                                occ_next  = occ_reg + 1'b1;
                                emit_res  = note(KIND_QUEUED, cmd.tag);
                            end
                        end
                        CMD_TICK: begin
                            now_next = now_reg + 1'b1;
                        end
                        CMD_PASS: begin
                            state_next = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (occ_reg == '0) begin
                    state_next = S_FINAL;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (timed_out) begin
                    if (can_emit) begin
                        emit_req   = 1'b1;
                        emit_res   = note(KIND_TIMEOUT, ent_tag);
                        head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_reg + 1'b1;
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_READ;
                    end
                end else if (overflows) begin
                    // the open batch already holds something, so it has started
                    full_next  = 1'b1;
                    state_next = S_FINAL;
                end else if (can_emit) begin
                    emit_req        = 1'b1;
                    emit_res        = note(KIND_TAKEN, ent_tag);
                    open_total_next = grown_total[15:0];
                    if (open_members_reg != 16'hFFFF) begin
                        open_members_next = open_members_reg + 1'b1;
                    end
                    if (!open_started_reg) begin
                        open_started_next = 1'b1;
                        open_stamp_next   = ent_stamp;
                    end
                    head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : head_reg + 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_READ;
                end
            end
            S_FINAL: begin
                if (full_reg || (open_started_reg && interval_up)) begin
                    if (can_emit) begin
                        emit_req               = 1'b1;
                        emit_res               = '0;
                        emit_res.kind          = KIND_SENT;
                        emit_res.lane          = lane_sel[3:0];
                        emit_res.batch_total   = open_total_reg;
                        emit_res.batch_members = open_members_reg;
                        emit_res.batch_start   = stamp_ext[31:0];
                        emit_res.was_full      = full_reg;
                        next_lane_next         = LANE_W'(lane_inc);
                        open_total_next        = '0;
                        open_members_next      = '0;
                        open_started_next      = 1'b0;
                        open_stamp_next        = '0;
                        full_next              = 1'b0;
                        state_next             = S_FLUSH;
                    end
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // release the held result as the last one of this command
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_push        = 1'b1;
                    push_res        = hold_reg;
                    push_res.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a new result pushes the held one out, which then cannot be the last
        if (emit_req) begin
            if (hold_valid_reg) begin
                out_push      = 1'b1;
                push_res      = hold_reg;
                push_res.last = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = emit_res;
        end

        if (out_push) begin
            out_valid_next = 1'b1;
            out_res_next   = push_res;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            occ_reg          <= '0;
            now_reg          <= '0;
            open_total_reg   <= '0;
            open_members_reg <= '0;
            open_started_reg <= 1'b0;
            open_stamp_reg   <= '0;
            next_lane_reg    <= '0;
            full_reg         <= 1'b0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            occ_reg          <= occ_next;
            now_reg          <= now_next;
            open_total_reg   <= open_total_next;
            open_members_reg <= open_members_next;
            open_started_reg <= open_started_next;
            open_stamp_reg   <= open_stamp_next;
            next_lane_reg    <= next_lane_next;
            full_reg         <= full_next;
            hold_valid_reg   <= hold_valid_next;
            out_valid_reg    <= out_valid_next;
        end
        hold_reg    <= hold_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("pending occupancy above queue depth");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("result still held while idle");

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> occ_reg != '0)
        else $error("pending entry read from an empty queue");

    a_sent_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_req && emit_res.kind == KIND_SENT |=> !open_started_reg && open_total_reg == '0)
        else $error("batch still open after it was sent");

endmodule

// ===== rtl/core/request_batch_former.sv =====
// Top level of the request batch former: ports, configuration and packing.
//
// The block gathers requests into batches. Each input beat carries a command
// in s_tuser: enqueue a request (size, tag) into the pending FIFO, advance the
// tick counter by one, or run one forming pass. An enqueue answers with one
// result beat: queued, refused because the FIFO is full, or refused because
// the size is zero. A pass drops head entries that have waited at least
// queue_timeout ticks, takes entries into the open batch while they fit under
// max_batch_size (the first one always fits), and sends the batch to the next
// lane in round robin when the next entry does not fit or batching_interval
// ticks have gone by since its first entry. Each of these events is one
// result beat; m_tlast marks the final beat caused by one command, and a pass
// with nothing to do gives no beat at all. After a flush because the batch
// was full, send another pass to carry on. Steps: a tick is handled in the
// idle state, and an enqueue releases its result in the flush state; a pass
// reads each entry it drops or takes from the pending memory, whose read is
// registered, and judges it in the evaluate state, then ends in the final
// and flush states, waiting wherever m_tready holds results back. The front
// end queues two commands while a pass runs, and a one-beat output register lets
// the back end carry on while a result beat waits for m_tready. Write the
// configuration registers only while the block is idle; their indexes are
// 0 max_batch_size, 1 queue_timeout, 2 batching_interval, 3 lane_count.
module request_batch_former import rbf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_LANES   = MAX_LANES_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // command beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_size[15:0], request_tag[31:16]
    input  logic [S_TUSER_W-1:0] s_tuser,   // command[1:0]
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // tag[15:0], lane[19:16],
                                            // batch_total[35:20], batch_members[51:36],
                                            // batch_start[83:52], was_full[84], zero above
    output logic [M_TUSER_W-1:0] m_tuser,   // kind[2:0]
    output logic                 m_tlast
);

    cfg_t    cfg_reg;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    result_t res;

    // Hold the configuration; a write masks the value to the register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_batch_size    <= 16'd256;
            cfg_reg.queue_timeout     <= 20'd100;
            cfg_reg.batching_interval <= 20'd2;
            cfg_reg.lane_count        <= 5'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_BATCH: cfg_reg.max_batch_size    <= cfg_wdata[15:0];
                REG_TIMEOUT:   cfg_reg.queue_timeout     <= cfg_wdata;
                REG_INTERVAL:  cfg_reg.batching_interval <= cfg_wdata;
                REG_LANES:     cfg_reg.lane_count        <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    rbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    rbf_engine #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_LANES  (MAX_LANES),
        .STAMP_BITS (STAMP_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .out_valid(m_tvalid),
        .out_res  (res),
        .out_ready(m_tready)
    );

    // Pack the result beat
    assign m_tdata = {3'b000, res.was_full, res.batch_start, res.batch_members,
                      res.batch_total, res.lane, res.tag};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the request batch former: directed and random command beats.
`timescale 1ns / 100ps

module tb;
    import rbf_pkg::*;

    // Cycles without any accepted beat before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // Settling time after the last due result; covers a pass over a full FIFO
    localparam int SETTLE_CYCLES = 64;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // request_size[15:0], request_tag[31:16]
    logic [S_TUSER_W-1:0] s_tuser   = '0;   // command[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // tag[15:0], lane[19:16], batch_total[35:20],
                                            // batch_members[51:36], batch_start[83:52],
                                            // was_full[84]
    logic [M_TUSER_W-1:0] m_tuser;          // kind[2:0]
    logic                 m_tlast;

    request_batch_former uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Command beats waiting to be driven, and results the block still owes us
    cmd_t    cmd_backlog[$];
    result_t due_results[$];

    int n_queued = 0;   // beats put in the backlog
    int n_real   = 0;   // of those, beats the block does not ignore
    int n_taken  = 0;   // beats accepted by the block
    int errors   = 0;
    int stall_cycles = 0;
    int tx_idle  = 0;   // percentage of cycles the sender holds off
    int rx_idle  = 0;   // percentage of cycles the receiver stalls

    cmd_t    nxt;
    result_t want;

    // Shadow of the configuration registers, reset values
    logic [15:0] lim_batch    = 16'd256;
    logic [19:0] lim_wait     = 20'd100;
    logic [19:0] lim_interval = 20'd2;
    logic [4:0]  lim_lanes    = 5'd1;

    // Shadow of the pending FIFO and the open batch
    logic [15:0] fifo_size [16];
    logic [15:0] fifo_tag  [16];
    logic [31:0] fifo_stamp[16];
    logic [3:0]  rd_ptr      = '0;
    logic [3:0]  wr_ptr      = '0;
    int          fill        = 0;
    logic [31:0] tick_now    = '0;
    logic [15:0] batch_sum   = '0;
    logic [15:0] batch_count = '0;
    logic        batch_open  = 1'b0;
    logic [31:0] batch_t0    = '0;
    int          lane_ptr    = 0;

    // Result about one request: batch fields stay zero
    function automatic result_t request_note(input logic [2:0] kind, input logic [15:0] tag);
        result_t r;
        r      = '0;
        r.kind = kind;
        r.tag  = tag;
        return r;
    endfunction

    // Advance the shadow state by one accepted command beat and queue what it owes
    task automatic predict_batcher(input logic [1:0] op, input logic [15:0] size,
                                   input logic [15:0] tag);
        result_t     staged[$];
        result_t     r;
        logic [31:0] age;
        logic        full_flush;
        logic        stop;
        int          cnt;
        int          lane;
        int          i;
        full_flush = 1'b0;
        stop       = 1'b0;
        case (op)
            CMD_ENQ: begin
                // zero size is judged before the FIFO level
                if (size == 16'd0) begin
                    staged = {staged, request_note(KIND_ZERO, tag)};
                end else if (fill >= 16) begin
                    staged = {staged, request_note(KIND_FULL, tag)};
                end else begin
                    fifo_size[wr_ptr]  = size;
                    fifo_tag[wr_ptr]   = tag;
                    fifo_stamp[wr_ptr] = tick_now;
                    wr_ptr = wr_ptr + 4'd1;
                    fill++;
                    staged = {staged, request_note(KIND_QUEUED, tag)};
                end
            end
            CMD_TICK: begin
                tick_now = tick_now + 32'd1;
            end
            CMD_PASS: begin
                while (fill != 0 && !stop) begin
                    age = tick_now - fifo_stamp[rd_ptr];
                    if (age >= {12'd0, lim_wait}) begin
                        // stale head: drop it
                        staged = {staged, request_note(KIND_TIMEOUT, fifo_tag[rd_ptr])};
                        rd_ptr = rd_ptr + 4'd1;
                        fill--;
                    end else begin
                        if (!batch_open) begin
                            batch_open = 1'b1;
                            batch_t0   = fifo_stamp[rd_ptr];
                        end
                        // an empty batch takes any request, even an oversized one
                        if (batch_sum != 16'd0 &&
                            ({1'b0, batch_sum} + {1'b0, fifo_size[rd_ptr]}) >
                            {1'b0, lim_batch}) begin
                            full_flush = 1'b1;
                            stop       = 1'b1;
                        end else begin
                            staged = {staged, request_note(KIND_TAKEN, fifo_tag[rd_ptr])};
                            batch_sum = batch_sum + fifo_size[rd_ptr];
                            if (batch_count != 16'hFFFF)
                                batch_count = batch_count + 16'd1;
                            rd_ptr = rd_ptr + 4'd1;
                            fill--;
                        end
                    end
                end
                if (full_flush ||
                    (batch_open && (tick_now - batch_t0) >= {12'd0, lim_interval})) begin
                    // clamp the lane count, fall back to lane 0 when the pointer is out of range
                    cnt = int'(lim_lanes);
                    if (cnt == 0)
                        cnt = 1;
                    if (cnt > 16)
                        cnt = 16;
                    lane = (lane_ptr < cnt) ? lane_ptr : 0;
                    r               = '0;
                    r.kind          = KIND_SENT;
                    r.lane          = lane[3:0];
                    r.batch_total   = batch_sum;
                    r.batch_members = batch_count;
                    r.batch_start   = batch_t0;
                    r.was_full      = full_flush;
                    staged = {staged, r};
                    lane_ptr    = (lane + 1 >= cnt) ? 0 : lane + 1;
                    batch_sum   = '0;
                    batch_count = '0;
                    batch_open  = 1'b0;
                    batch_t0    = '0;
                end
            end
            default: begin
                // unknown command: ignored
            end
        endcase
        for (i = 0; i < staged.size(); i++) begin
            r      = staged[i];
            r.last = (i == staged.size() - 1);
            due_results = {due_results, r};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
            errors++;
        end
    endtask

    // Driver: predict on acceptance, then present the next beat or hold off
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_batcher(s_tuser, s_tdata[15:0], s_tdata[31:16]);
                n_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    nxt = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {nxt.tag, nxt.size};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Monitor: compare every result beat with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t ns: result beat with none due, expected none, got kind %0d tag %0h",
                         $time, m_tuser, m_tdata[15:0]);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("kind",          32'(want.kind),          32'(m_tuser));
                check_field("tag",           32'(want.tag),           32'(m_tdata[15:0]));
                check_field("lane",          32'(want.lane),          32'(m_tdata[19:16]));
                check_field("batch_total",   32'(want.batch_total),   32'(m_tdata[35:20]));
                check_field("batch_members", 32'(want.batch_members), 32'(m_tdata[51:36]));
                check_field("batch_start",   want.batch_start,        m_tdata[83:52]);
                check_field("was_full",      32'(want.was_full),      32'(m_tdata[84]));
                check_field("last",          32'(want.last),          32'(m_tlast));
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [15:0] size,
                             input logic [15:0] tag);
        cmd_t c;
        c.op   = op;
        c.size = size;
        c.tag  = tag;
        cmd_backlog = {cmd_backlog, c};
        n_queued++;
        if (op != CMD_NONE)
            n_real++;
    endtask

    // Mostly small sizes so batches fill; zero, all-ones and wide values now and then
    function automatic logic [15:0] pick_size();
        int          r;
        logic [31:0] v;
        r = $urandom_range(99);
        v = $urandom;
        if (r < 8)
            return 16'd0;
        if (r < 14)
            return 16'hFFFF;
        if (r < 30)
            return v[15:0];
        v = $urandom_range(64, 1);
        return v[15:0];
    endfunction

    // Hold the sender until every beat is taken and every result has come, then settle
    task automatic drain();
        while (n_taken != n_queued || due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all four registers on consecutive edges; the block is idle here
    task automatic set_config(input logic [19:0] mb, input logic [19:0] to,
                              input logic [19:0] iv, input logic [19:0] ln);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_BATCH;
        cfg_wdata <= mb;
        lim_batch = mb[15:0];
        @(posedge aclk);
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= to;
        lim_wait = to;
        @(posedge aclk);
        cfg_index <= REG_INTERVAL;
        cfg_wdata <= iv;
        lim_interval = iv;
        @(posedge aclk);
        cfg_index <= REG_LANES;
        cfg_wdata <= ln;
        lim_lanes = ln[4:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Random rounds: bursts of requests with ticks mixed in, then ticks and passes;
    // a quarter of the time a lone beat of any command, unknown ones included
    task automatic random_rounds(input int count);
        int goal;
        int k;
        int j;
        goal = n_real + count;
        while (n_real < goal) begin
            if ($urandom_range(99) < 75) begin
                k = $urandom_range(20, 1);
                for (j = 0; j < k; j++) begin
                    if ($urandom_range(4) == 0)
                        queue_cmd(CMD_TICK, 16'($urandom), 16'($urandom));
                    else
                        queue_cmd(CMD_ENQ, pick_size(), 16'($urandom));
                end
                k = $urandom_range(3);
                for (j = 0; j < k; j++)
                    queue_cmd(CMD_TICK, 16'($urandom), 16'($urandom));
                k = $urandom_range(4, 1);
                for (j = 0; j < k; j++)
                    queue_cmd(CMD_PASS, 16'($urandom), 16'($urandom));
            end else begin
                queue_cmd(2'($urandom_range(3)), pick_size(), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Light sender idling, heavy receiver stalls
        tx_idle = 6;
        rx_idle = 72;

        // Reset settings: zero size, field extremes, unknown command, oversized
        // first request, flush on full, flush on interval, quiet pass
        queue_cmd(CMD_ENQ,  16'h0000, 16'hFFFF);
        queue_cmd(CMD_ENQ,  16'hFFFF, 16'hFFFF);
        queue_cmd(CMD_ENQ,  16'h0001, 16'h0000);
        queue_cmd(CMD_ENQ,  16'd200,  16'h0001);
        queue_cmd(CMD_NONE, 16'hFFFF, 16'hFFFF);
        queue_cmd(CMD_PASS, 16'h0000, 16'h0000);
        queue_cmd(CMD_PASS, 16'h0000, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000, 16'h0000);
        queue_cmd(CMD_PASS, 16'h0000, 16'h0000);
        queue_cmd(CMD_PASS, 16'h0000, 16'h0000);
        drain();

        // Zero timeout drops everything at the next pass; lane count 0 acts as 1
        set_config(20'd0, 20'd0, 20'd0, 20'd0);
        queue_cmd(CMD_ENQ,  16'd5, 16'hA5A5);
        queue_cmd(CMD_ENQ,  16'd7, 16'h5A5A);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        drain();

        // Zero batch size: each batch holds one request
        set_config(20'd0, 20'd5, 20'd0, 20'd0);
        queue_cmd(CMD_ENQ,  16'd5, 16'h1234);
        queue_cmd(CMD_ENQ,  16'd7, 16'h4321);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        drain();

        // Over-wide writes get masked; lane count above the maximum clamps
        set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd31);
        queue_cmd(CMD_ENQ,  16'd40000, 16'h0F0F);
        queue_cmd(CMD_ENQ,  16'd40000, 16'hF0F0);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        queue_cmd(CMD_ENQ,  16'hFFFF, 16'hFFFF);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        queue_cmd(CMD_PASS, 16'd0, 16'd0);
        drain();

        // Reset-like settings; stop the sender halfway until all results are in
        set_config(20'd256, 20'd100, 20'd2, 20'd1);
        random_rounds(40);
        drain();
        random_rounds(40);
        drain();

        // One request per batch, sent only when full, all sixteen lanes
        set_config(20'd1, 20'd1048575, 20'd1048575, 20'd16);
        random_rounds(80);
        drain();

        // Swap the idling: slow sender, eager receiver
        tx_idle = 72;
        rx_idle = 6;

        // Fewer lanes than the pointer may hold; every tick makes entries stale
        set_config(20'd65535, 20'd1, 20'd0, 20'd3);
        random_rounds(80);
        drain();

        set_config(20'd100, 20'd8, 20'd4, 20'd16);
        random_rounds(80);
        drain();

        // No idling on either side
        tx_idle = 0;
        rx_idle = 0;

        set_config(20'd300, 20'd20, 20'd1048575, 20'd7);
        random_rounds(80);
        drain();

        set_config(20'd64, 20'd1048575, 20'd0, 20'd5);
        random_rounds(80);
        drain();

        if (errors == 0 && due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
